// ===== hdl/actr_pkg.sv =====
// Shared types, constants and AES round functions for the AES-128 CTR byte cipher.
// Used by every module under hdl but actr_checker; depends on nothing else.

package actr_pkg;

	// Configuration register indexes.
	localparam logic [2:0] CFG_KEY_HIGH      = 3'd0;
	localparam logic [2:0] CFG_KEY_LOW       = 3'd1;
	localparam logic [2:0] CFG_NONCE_HIGH    = 3'd2;
	localparam logic [2:0] CFG_NONCE_LOW     = 3'd3;
	localparam logic [2:0] CFG_COUNTER_START = 3'd4;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam logic [3:0] LAST_ROUND = 4'd10;

	// One classified byte travelling from the front to the back.
	typedef struct packed {
		logic [7:0]  data;
		logic        last;
		logic [3:0]  pos;
		logic        need;  // Byte opens a keystream block.
		logic [31:0] ctr;   // Counter of that block.
	} actr_item_t;

	// Request to the round engine.
	typedef struct packed {
		logic        start;
		logic [31:0] ctr;
	} actr_eng_req_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	// Multiply by x in GF(2^8).
	function automatic logic [7:0] xtime(input logic [7:0] a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// Round constant for rounds one to ten.
	function automatic logic [7:0] rcon(input logic [3:0] rnd);
		unique case (rnd)
			4'd1:    rcon = 8'h01;
			4'd2:    rcon = 8'h02;
			4'd3:    rcon = 8'h04;
			4'd4:    rcon = 8'h08;
			4'd5:    rcon = 8'h10;
			4'd6:    rcon = 8'h20;
			4'd7:    rcon = 8'h40;
			4'd8:    rcon = 8'h80;
			4'd9:    rcon = 8'h1b;
			4'd10:   rcon = 8'h36;
			default: rcon = 8'h00;
		endcase
	endfunction

	// S-box applied to each byte of a word.
	function automatic logic [31:0] sbox_word(input logic [31:0] w);
		sbox_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	// Next round key from the previous one; word 0 sits in bits 127..96.
	function automatic logic [127:0] next_round_key(input logic [127:0] rk,
		input logic [7:0] rc);
		logic [31:0] w0, w1, w2, w3;
		w0 = rk[127:96] ^ sbox_word({rk[23:0], rk[31:24]}) ^ {rc, 24'h0};
		w1 = rk[95:64] ^ w0;
		w2 = rk[63:32] ^ w1;
		w3 = rk[31:0] ^ w2;
		next_round_key = {w0, w1, w2, w3};
	endfunction

	// One cipher round; byte i of the state sits in bits 127-8i..120-8i.
	function automatic logic [127:0] aes_round(input logic [127:0] s,
		input logic [127:0] rk, input logic last);
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, all;
		logic [127:0] m;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[4*c+r] = SBOX[s[8*(15-(4*((c+r)%4)+r)) +: 8]];
			end
		end
		for (int c = 0; c < 4; c++) begin
			a0 = t[4*c];
			a1 = t[4*c+1];
			a2 = t[4*c+2];
			a3 = t[4*c+3];
			all = a0 ^ a1 ^ a2 ^ a3;
			if (last) begin
				m[8*(15-4*c) +: 8]     = a0;
				m[8*(14-4*c) +: 8]     = a1;
				m[8*(13-4*c) +: 8]     = a2;
				m[8*(12-4*c) +: 8]     = a3;
			end else begin
				m[8*(15-4*c) +: 8]     = a0 ^ all ^ xtime(a0 ^ a1);
				m[8*(14-4*c) +: 8]     = a1 ^ all ^ xtime(a1 ^ a2);
				m[8*(13-4*c) +: 8]     = a2 ^ all ^ xtime(a2 ^ a3);
				m[8*(12-4*c) +: 8]     = a3 ^ all ^ xtime(a3 ^ a0);
			end
		end
		aes_round = m ^ rk;
	endfunction

endpackage

// ===== hdl/aes128_ctr_cipher.sv =====
// Top level of the AES-128 CTR byte cipher: configuration registers, front, queue, back.
// Depends on actr_pkg, actr_front, actr_queue and actr_back.
//
//   Channel   Direction  Handshake             Payload
//   input     in         in_valid / in_stall   data_byte, first_byte, last_byte
//   output    out        out_valid / out_stall out_byte, out_last
//   config    in         cfg_we                cfg_index, cfg_data
//
// One byte per cycle while the next keystream block is ready and out_stall is low;
// the iterative round engine encrypts a block ahead during the previous block's bytes.
// A byte that restarts a message or misses the prefetch waits for the round engine.
// Reset clears the counter, position, queue and output register; no clearing pass.
// A stalled output holds its byte while up to four more bytes enter the queue.

module aes128_ctr_cipher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        out_last,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import actr_pkg::*;

	logic [63:0] key_high_q;
	logic [63:0] key_low_q;
	logic [63:0] nonce_high_q;
	logic [31:0] nonce_low_q;
	logic [31:0] counter_start_q;

	logic        q_full;
	logic        push;
	logic        pop;
	logic        head_valid;
	actr_item_t  push_item;
	actr_item_t  head;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q      <= '0;
			key_low_q       <= '0;
			nonce_high_q    <= '0;
			nonce_low_q     <= '0;
			counter_start_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_KEY_HIGH:      key_high_q      <= cfg_data;
				CFG_KEY_LOW:       key_low_q       <= cfg_data;
				CFG_NONCE_HIGH:    nonce_high_q    <= cfg_data;
				CFG_NONCE_LOW:     nonce_low_q     <= cfg_data[31:0];
				CFG_COUNTER_START: counter_start_q <= cfg_data[31:0];
				default:           ;
			endcase
		end
	end

	actr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.q_full        (q_full),
		.data_byte     (data_byte),
		.first_byte    (first_byte),
		.last_byte     (last_byte),
		.counter_start (counter_start_q),
		.in_stall      (in_stall),
		.push          (push),
		.item          (push_item)
	);

	actr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	actr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.key        ({key_high_q, key_low_q}),
		.nonce      ({nonce_high_q, nonce_low_q}),
		.cfg_write  (cfg_we),
		.out_stall  (out_stall),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_byte   (out_byte),
		.out_last   (out_last)
	);

endmodule

// ===== hdl/actr_front.sv =====
// Front end: accepts bytes, tracks counter and byte position, tags each byte.
// Depends on actr_pkg.

module actr_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 q_full,
	input  logic [7:0]           data_byte,
	input  logic                 first_byte,
	input  logic                 last_byte,
	input  logic [31:0]          counter_start,
	output logic                 in_stall,
	output logic                 push,
	output actr_pkg::actr_item_t item
);
	import actr_pkg::*;

	logic [31:0] block_counter_q;
	logic [3:0]  byte_pos_q;
	logic [31:0] ctr;
	logic [3:0]  pos;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	// A first byte restarts the counter and the position.
	always_comb begin
		ctr = first_byte ? counter_start : block_counter_q;
		pos = first_byte ? 4'd0 : byte_pos_q;
		item.data = data_byte;
		item.last = last_byte;
		item.pos  = pos;
		item.need = (pos == 4'd0);
		item.ctr  = ctr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_counter_q <= '0;
			byte_pos_q      <= '0;
		end else if (push) begin
			block_counter_q <= (pos == 4'd0) ? ctr + 32'd1 : ctr;
			byte_pos_q      <= pos + 4'd1;
		end
	end

endmodule

// ===== hdl/actr_queue.sv =====
// Short queue of tagged bytes between the front and the back end.
// Depends on actr_pkg.

module actr_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  actr_pkg::actr_item_t push_item,
	input  logic                 pop,
	output logic                 full,
	output logic                 head_valid,
	output actr_pkg::actr_item_t head
);
	import actr_pkg::*;

	actr_item_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     count_q;

	assign full       = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	// Storage needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/actr_core.sv =====
// Iterative AES-128 encryption engine, one round and one key step per cycle.
// Depends on actr_pkg.

module actr_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [127:0]   blk,
	input  logic [127:0]   key,
	output logic           busy,
	output logic           done,
	output logic [127:0]   result
);
	import actr_pkg::*;

	logic [127:0] state_q;
	logic [127:0] rk_q;
	logic [3:0]   round_q;
	logic         busy_q;
	logic [127:0] rk_next;

	// Round key expansion runs alongside the rounds.
	always_comb begin
		rk_next = next_round_key(rk_q, rcon(round_q));
		result  = aes_round(state_q, rk_next, round_q == LAST_ROUND);
	end

	assign busy = busy_q;
	assign done = busy_q && (round_q == LAST_ROUND) && !start;

	always_ff @(posedge clk) begin
		if (start) begin
			state_q <= blk ^ key;
			rk_q    <= key;
		end else if (busy_q) begin
			state_q <= result;
			rk_q    <= rk_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			round_q <= '0;
		end else if (start) begin
			busy_q  <= 1'b1;
			round_q <= 4'd1;
		end else if (busy_q) begin
			busy_q  <= (round_q != LAST_ROUND);
			round_q <= round_q + 4'd1;
		end
	end

endmodule

// ===== hdl/actr_back.sv =====
// Back end: keystream management with one-block prefetch, XOR and output register.
// Depends on actr_pkg and actr_core.

module actr_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  actr_pkg::actr_item_t head,
	input  logic [127:0]         key,
	input  logic [95:0]          nonce,
	input  logic                 cfg_write,
	input  logic                 out_stall,
	output logic                 pop,
	output logic                 out_valid,
	output logic [7:0]           out_byte,
	output logic                 out_last
);
	import actr_pkg::*;

	logic [127:0]  ks_q;
	logic [127:0]  pf_q;
	logic [31:0]   pf_ctr_q;
	logic          pf_valid_q;
	logic          dem_done_q;
	logic          eng_dem_q;
	logic [31:0]   eng_ctr_q;
	logic          stale_q;
	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          out_last_q;

	logic          pf_hit;
	logic          ks_ready;
	logic          can_load;
	logic          dem_start;
	logic          pf_start;
	logic [127:0]  ks_use;
	actr_eng_req_t req;
	logic          eng_busy;
	logic          eng_done;
	logic [127:0]  eng_result;

	// Decide whether the head byte has its keystream and what to run next.
	always_comb begin
		pf_hit    = pf_valid_q && (pf_ctr_q == head.ctr);
		ks_ready  = !head.need || dem_done_q || pf_hit;
		can_load  = !out_valid_q || !out_stall;
		pop       = head_valid && can_load && ks_ready;
		dem_start = head_valid && head.need && !pf_hit && !dem_done_q
			&& !(eng_busy && eng_dem_q);
		pf_start  = pop && head.need && !eng_busy;
		req.start = dem_start || pf_start;
		req.ctr   = dem_start ? head.ctr : head.ctr + 32'd1;
		ks_use    = (head.need && !dem_done_q) ? pf_q : ks_q;
	end

	actr_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (req.start),
		.blk    ({nonce, req.ctr}),
		.key    (key),
		.busy   (eng_busy),
		.done   (eng_done),
		.result (eng_result)
	);

	// Keystream and output payload registers.
	always_ff @(posedge clk) begin
		if (eng_done && eng_dem_q) begin
			ks_q <= eng_result;
		end else if (pop && head.need && !dem_done_q) begin
			ks_q <= pf_q;
		end
		if (eng_done && !eng_dem_q) begin
			pf_q     <= eng_result;
			pf_ctr_q <= eng_ctr_q;
		end
		if (req.start) begin
			eng_ctr_q <= req.ctr;
		end
		if (pop) begin
			out_byte_q <= head.data ^ ks_use[{~head.pos, 3'b000} +: 8];
			out_last_q <= head.last;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pf_valid_q  <= 1'b0;
			dem_done_q  <= 1'b0;
			eng_dem_q   <= 1'b0;
			stale_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (req.start) begin
				eng_dem_q <= dem_start;
				stale_q   <= 1'b0;
			end else if (cfg_write && eng_busy) begin
				stale_q <= 1'b1;
			end
			if (cfg_write) begin
				pf_valid_q <= 1'b0;
			end else if (eng_done && !eng_dem_q) begin
				pf_valid_q <= !stale_q;
			end
			if (eng_done && eng_dem_q) begin
				dem_done_q <= 1'b1;
			end else if (pop && head.need) begin
				dem_done_q <= 1'b0;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

endmodule

// ===== hdl/actr_checker.sv =====
// Port-level checker for the AES-128 CTR byte cipher, bound to the top level.
// Depends on aes128_ctr_cipher's ports only.

module actr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       out_last
);

	logic [3:0] pend_q;
	logic       in_xfer;
	logic       out_xfer;

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid && !out_stall;

	// Bytes taken in but not yet transferred out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_xfer && !out_xfer) begin
			pend_q <= pend_q + 4'd1;
		end else if (out_xfer && !in_xfer) begin
			pend_q <= pend_q - 4'd1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_byte) && $stable(out_last))
		else $error("output payload changed while stalled");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 4'd0)
		else $error("output shown with no byte outstanding");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 4'd5)
		else $error("more bytes outstanding than queue and output can hold");

endmodule

bind aes128_ctr_cipher actr_checker u_actr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_byte  (out_byte),
	.out_last  (out_last)
);
